FILE: rtl/s2x_pkg.sv
// ----------------------------------------------------------------------------
// s2x_pkg
// Shared types and constants for the Scale2x pixel upscaler.
// ----------------------------------------------------------------------------
package s2x_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int PIXEL_BITS   = 32;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS    = 11;
  localparam int CFG_IDX_BITS = 8;
  localparam int MIN_SIZE     = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // one line-store word: the two stored rows at one column
  typedef struct packed {
    pixel_t older;
    pixel_t prev;
  } line_pair_t;

  typedef struct packed {
    pixel_t top_left;
    pixel_t top_right;
    pixel_t bottom_left;
    pixel_t bottom_right;
  } quad_t;

endpackage

FILE: rtl/s2x_line_mem.sv
// ----------------------------------------------------------------------------
// s2x_line_mem
// Line store: both previous source rows packed per column, one read port
// and one write port, registered read data.
// ----------------------------------------------------------------------------
module s2x_line_mem
  import s2x_pkg::*;
(
  input  logic                clk,
  input  logic                rd_en,
  input  logic [COL_BITS-1:0] rd_addr,
  output line_pair_t          rd_data,
  input  logic                wr_en,
  input  logic [COL_BITS-1:0] wr_addr,
  input  line_pair_t          wr_data
);

  line_pair_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/s2x_kernel.sv
// ----------------------------------------------------------------------------
// s2x_kernel
// Neighborhood window and the Scale2x rule for one center pixel.
// ----------------------------------------------------------------------------
module s2x_kernel
  import s2x_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  pixel_t     pixel,
  input  line_pair_t line,
  output quad_t      quad
);

  pixel_t win_left, win_center, win_above, win_below;
  pixel_t right;
  logic   active;

  // right neighbor is the row above the arriving pixel
  assign right  = line.prev;
  assign active = (win_above != win_below) && (win_left != right);

  always_comb begin
    quad.top_left     = win_center;
    quad.top_right    = win_center;
    quad.bottom_left  = win_center;
    quad.bottom_right = win_center;
    if (active) begin
      if (win_left == win_above)  quad.top_left     = win_left;
      if (win_above == right)     quad.top_right    = right;
      if (win_left == win_below)  quad.bottom_left  = win_left;
      if (win_below == right)     quad.bottom_right = right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_center <= '0;
      win_above  <= '0;
      win_below  <= '0;
    end else if (advance) begin
      win_left   <= win_center;
      win_center <= line.prev;
      win_above  <= line.older;
      win_below  <= pixel;
    end
  end

endmodule

FILE: rtl/scale2x_pixel_upscaler.sv
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler
// Streaming Scale2x upscaler: raster pixels in, one 2x2 block per interior
// pixel out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel pixel_valid/pixel_stall/pixel carries the source frame in
//   raster order, one-pixel border included. Output channel
//   block_valid/block_stall carries one 2x2 block per interior pixel,
//   tagged with block_col/block_row; border pixels produce nothing.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data sets image_width
//   (index 0) and image_height (index 1); sizes clamp to 3..1024 and any
//   write to those restarts the frame at the top left corner.
//   Write config only while the block is idle.
//   Throughput is one pixel per clock unless the output stalls: the line
//   store is read at accept and written back when the pixel leaves the s1
//   read stage, always at a different column. Blocks are registered after s1.
//   Reset clears counters and pipeline valids; sizes return to 1024x1024.
//   Line store contents are not cleared and need no clearing pass.
//   A stalled output holds its block; one more request is absorbed by the
//   read stage, after which pixel_stall rises.
// ----------------------------------------------------------------------------
module scale2x_pixel_upscaler
  import s2x_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pixel_valid,
  output logic                    pixel_stall,
  input  logic [PIXEL_BITS-1:0]   pixel,
  output logic                    block_valid,
  input  logic                    block_stall,
  output logic [COL_BITS-1:0]     block_col,
  output logic [ROW_BITS-1:0]     block_row,
  output logic [PIXEL_BITS-1:0]   top_left,
  output logic [PIXEL_BITS-1:0]   top_right,
  output logic [PIXEL_BITS-1:0]   bottom_left,
  output logic [PIXEL_BITS-1:0]   bottom_right,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SIZE_BITS-1:0]    cfg_data
);

  logic [COL_BITS-1:0] col, width_last;
  logic [ROW_BITS-1:0] row, height_last;
  logic [COL_BITS-1:0] width_last_next;
  logic [ROW_BITS-1:0] height_last_next;

  logic                s1_valid;
  pixel_t              s1_pixel;
  logic [COL_BITS-1:0] s1_col;
  logic [ROW_BITS-1:0] s1_row;
  logic                s1_adv, s1_emit;
  logic                accept, cfg_write;

  line_pair_t line_rd, line_wr;
  quad_t      quad;

  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && (cfg_index == REG_IMAGE_WIDTH ||
                                     cfg_index == REG_IMAGE_HEIGHT);
  assign s1_adv      = s1_valid && (!block_valid || !block_stall);
  assign pixel_stall = s1_valid && !s1_adv;
  assign accept      = pixel_valid && !pixel_stall;
  assign s1_emit     = (s1_col >= COL_BITS'(2)) && (s1_row >= ROW_BITS'(2));

  // clamp to 3..MAX, keep size minus one
  always_comb begin
    if (cfg_data < SIZE_BITS'(MIN_SIZE)) begin
      width_last_next  = COL_BITS'(MIN_SIZE - 1);
      height_last_next = ROW_BITS'(MIN_SIZE - 1);
    end else begin
      width_last_next  = (cfg_data > SIZE_BITS'(MAX_WIDTH)) ?
                         COL_BITS'(MAX_WIDTH - 1) : COL_BITS'(cfg_data - 1'b1);
      height_last_next = (cfg_data > SIZE_BITS'(MAX_HEIGHT)) ?
                         ROW_BITS'(MAX_HEIGHT - 1) : ROW_BITS'(cfg_data - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= COL_BITS'(MAX_WIDTH - 1);
      height_last <= ROW_BITS'(MAX_HEIGHT - 1);
      col         <= '0;
      row         <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_last <= width_last_next;
      end else begin
        height_last <= height_last_next;
      end
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == width_last) begin
        col <= '0;
        row <= (row == height_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_col   <= col;
      s1_row   <= row;
    end
  end

  // consecutive requests never share a column, so no forwarding is needed
  assign line_wr.older = line_rd.prev;
  assign line_wr.prev  = s1_pixel;

  s2x_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (line_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (line_wr)
  );

  s2x_kernel u_kernel (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_adv),
    .pixel   (s1_pixel),
    .line    (line_rd),
    .quad    (quad)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_valid <= 1'b0;
    end else if (s1_adv) begin
      block_valid <= s1_emit;
    end else if (!block_stall) begin
      block_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      block_col    <= s1_col - COL_BITS'(2);
      block_row    <= s1_row - ROW_BITS'(2);
      top_left     <= quad.top_left;
      top_right    <= quad.top_right;
      bottom_left  <= quad.bottom_left;
      bottom_right <= quad.bottom_right;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Scale2x upscaler. A behavioral predictor tracks
// line stores, window and raster position for every accepted pixel request
// and queues the expected 2x2 blocks; a checker compares each accepted block
// field by field. Directed frames cover the quadrant rules, size clamping,
// unused register indexes, frame wrap, a long output hold-off and a full drain
// pause. Random frames follow, with bursty input and random output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import s2x_pkg::*;

  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_PIXELS   = 180;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LOW  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HIGH = '1;

  typedef struct {
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    quad_t               quad;
  } block_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    pixel_valid = 1'b0;
  logic                    pixel_stall;
  logic [PIXEL_BITS-1:0]   pixel = '0;
  logic                    block_valid;
  logic                    block_stall = 1'b0;
  logic [COL_BITS-1:0]     block_col;
  logic [ROW_BITS-1:0]     block_row;
  logic [PIXEL_BITS-1:0]   top_left;
  logic [PIXEL_BITS-1:0]   top_right;
  logic [PIXEL_BITS-1:0]   bottom_left;
  logic [PIXEL_BITS-1:0]   bottom_right;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [SIZE_BITS-1:0]    cfg_data = '0;

  scale2x_pixel_upscaler dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .block_valid  (block_valid),
    .block_stall  (block_stall),
    .block_col    (block_col),
    .block_row    (block_row),
    .top_left     (top_left),
    .top_right    (top_right),
    .bottom_left  (bottom_left),
    .bottom_right (bottom_right),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  pixel_t      line_prev [MAX_WIDTH];
  pixel_t      line_older[MAX_WIDTH];
  pixel_t      win_left, win_center, win_above, win_below;
  int unsigned col_pos, row_pos, width_reg, height_reg;
  block_t      expected_blocks[$];
  int          mismatch_count = 0;

  // pixel source
  pixel_t palette[3];
  int     palette_len;
  int     burst_left = 0;
  bit     gaps_on = 1'b1;

  // receiver hold-off bookkeeping
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_phase = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned limit);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > limit) return limit;
    return v;
  endfunction

  // one accepted pixel: emit the block for the pixel up and to the left, if interior
  function automatic void upscale_pixel(pixel_t px);
    int unsigned w, h, c, r;
    pixel_t      right_nb, above_here;
    block_t      blk;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    right_nb   = line_prev[c];
    above_here = line_older[c];
    if (r >= 2 && c >= 2) begin
      blk.col  = COL_BITS'(c - 2);
      blk.row  = ROW_BITS'(r - 2);
      blk.quad = {4{win_center}};
      if (win_above != win_below && win_left != right_nb) begin
        if (win_left == win_above) blk.quad.top_left = win_left;
        if (win_above == right_nb) blk.quad.top_right = right_nb;
        if (win_left == win_below) blk.quad.bottom_left = win_left;
        if (win_below == right_nb) blk.quad.bottom_right = right_nb;
      end
      expected_blocks.push_back(blk);
    end
    line_older[c] = right_nb;
    line_prev[c]  = px;
    win_left   = win_center;
    win_center = right_nb;
    win_above  = above_here;
    win_below  = px;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function automatic void check_field(string name, logic [PIXEL_BITS-1:0] want,
                                      logic [PIXEL_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_blocks
    block_t want;
    if (!rst && block_valid === 1'b1 && block_stall === 1'b0) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: block_valid mismatch, expected none, actual col %0d row %0d",
                 $time, block_col, block_row);
        mismatch_count++;
      end else begin
        want = expected_blocks.pop_front();
        check_field("block_col", PIXEL_BITS'(want.col), PIXEL_BITS'(block_col));
        check_field("block_row", PIXEL_BITS'(want.row), PIXEL_BITS'(block_row));
        check_field("top_left", want.quad.top_left, top_left);
        check_field("top_right", want.quad.top_right, top_right);
        check_field("bottom_left", want.quad.bottom_left, bottom_left);
        check_field("bottom_right", want.quad.bottom_right, bottom_right);
      end
    end
  end

  // receiver: periodic quiet window, random stalls otherwise, long hold on request
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 256;
    if (hold_left > 0) begin
      block_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_OFF_CYCLES - 1;
      block_stall <= 1'b1;
    end else begin
      block_stall <= (stall_phase >= 64) && ($urandom_range(0, 2) == 0);
    end
  end

  function automatic void new_palette();
    palette_len = $urandom_range(1, 3);
    foreach (palette[i])
      case ($urandom_range(0, 3))
        0:       palette[i] = '0;
        1:       palette[i] = '1;
        default: palette[i] = $urandom;
      endcase
  endfunction

  // mostly palette colors so neighbors match often; some noise
  function automatic pixel_t pick_pixel();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return palette[$urandom_range(0, palette_len - 1)];
  endfunction

  task automatic send_pixel(pixel_t px);
    int gap;
    pixel_valid <= 1'b1;
    pixel       <= px;
    @(posedge clk);
    while (pixel_stall !== 1'b0) @(posedge clk);
    upscale_pixel(px);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        pixel_valid <= 1'b0;
        repeat (gap) @(negedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_pixels(int n);
    repeat (n) send_pixel(pick_pixel());
  endtask

  // 3x3 frame around one interior pixel; corners are don't-care
  task automatic send_grid(pixel_t above, pixel_t left_px, pixel_t mid, pixel_t right_px,
                           pixel_t below);
    send_pixel($urandom);
    send_pixel(above);
    send_pixel($urandom);
    send_pixel(left_px);
    send_pixel(mid);
    send_pixel(right_px);
    send_pixel($urandom);
    send_pixel(below);
    send_pixel($urandom);
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    // border pixels may still be in flight with nothing queued
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = val;
      col_pos   = 0;
      row_pos   = 0;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = val;
      col_pos    = 0;
      row_pos    = 0;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(int w, int h);
    write_reg(REG_IMAGE_WIDTH, SIZE_BITS'(w));
    write_reg(REG_IMAGE_HEIGHT, SIZE_BITS'(h));
  endtask

  // default 1024x1024: top row only, nothing comes out
  task automatic test_reset_size();
    send_pixel('0);
    send_pixel('1);
    send_pixel($urandom);
    send_pixel($urandom);
  endtask

  task automatic test_quadrant_rules();
    set_size(0, 2);  // both clamp up to 3
    send_grid('0, '0, 32'h5a5a_a5a5, '1, '1);
    send_grid(32'ha5a5_0f0f, 32'h1234_5678, $urandom, 32'ha5a5_0f0f, 32'h1234_5678);
    send_grid(32'h0000_ffff, 32'h00ff_00ff, $urandom, 32'h00ff_00ff, 32'h0000_ffff);
  endtask

  // writes to unused indexes mid-frame must not restart the raster
  task automatic test_unused_index();
    new_palette();
    send_pixels(4);
    write_reg(REG_SPARE_LOW, SIZE_BITS'(5));
    write_reg(REG_SPARE_HIGH, '1);
    send_pixels(5);
  endtask

  // width clamps to the maximum; start of the top row only, nothing comes out
  task automatic test_wide_frame();
    set_size(2047, 3);
    new_palette();
    send_pixels(40);
  endtask

  task automatic test_tall_frame();
    set_size(3, 2047);
    new_palette();
    send_pixels(3 * 30);
  endtask

  task automatic test_backpressure();
    set_size(6, 10);
    new_palette();
    gaps_on = 1'b0;
    hold_requests++;
    send_pixels(50);
    gaps_on = 1'b1;
    drain_results();
    send_pixels(40);
  endtask

  task automatic test_random_frames();
    int w, h, n, shape, sent;
    bit restart_needed;
    sent = 0;
    restart_needed = 1'b1;
    while (sent < RANDOM_PIXELS) begin
      w     = $urandom_range(3, 9);
      h     = $urandom_range(3, 7);
      shape = $urandom_range(0, 9);
      if (restart_needed || $urandom_range(0, 1)) begin
        write_reg(REG_IMAGE_WIDTH, SIZE_BITS'((w == 3) ? $urandom_range(0, 3) : w));
        if (restart_needed || $urandom_range(0, 1))
          write_reg(REG_IMAGE_HEIGHT, SIZE_BITS'((h == 3) ? $urandom_range(0, 3) : h));
      end
      if (shape == 9)
        write_reg(CFG_IDX_BITS'($urandom_range(2, 255)), SIZE_BITS'($urandom));
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      new_palette();
      if (shape == 0) begin
        n = $urandom_range(1, w * h - 1);  // truncated frame
        restart_needed = 1'b1;
      end else if (shape == 1) begin
        n = w * h + $urandom_range(1, w * h);  // runs into the next frame
        restart_needed = 1'b1;
      end else begin
        n = w * h;
        restart_needed = 1'b0;
      end
      send_pixels(n);
      sent += n;
    end
  endtask

  initial begin
    foreach (line_prev[i]) begin
      line_prev[i]  = '0;
      line_older[i] = '0;
    end
    win_left   = '0;
    win_center = '0;
    win_above  = '0;
    win_below  = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = MAX_WIDTH;
    height_reg = MAX_HEIGHT;
    new_palette();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_size();
    test_quadrant_rules();
    test_unused_index();
    test_wide_frame();
    test_tall_frame();
    test_backpressure();
    test_random_frames();

    drain_results();
    if (mismatch_count == 0 && expected_blocks.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
